@@ hw/rtl/lsfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfc_pkg
// types and constants shared by the latin square forward check core
// ----------------------------------------------------------------------------
package lsfc_pkg;

	localparam int MAX_ORDER = 16;
	localparam int CELLS     = MAX_ORDER * MAX_ORDER;
	localparam int CELL_W    = $clog2(CELLS);
	localparam int IDX_W     = $clog2(MAX_ORDER);
	localparam logic [4:0] CNT_MAX     = 5'd31;
	localparam logic [4:0] RESET_ORDER = 5'd10;

	localparam logic [1:0] CMD_PLACE  = 2'd0;
	localparam logic [1:0] CMD_REMOVE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_WIPEOUT  = 2'd1;
	localparam logic [1:0] ST_UNDERFLW = 2'd2;

	localparam logic [0:0] REG_SIZE = 1'b0;

	typedef struct packed {
		logic [1:0] cmd;
		logic [3:0] cell_row;
		logic [3:0] cell_col;
		logic [4:0] cell_value;
	} item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  free_count;
		logic [15:0] allowed_mask;
		logic [4:0]  placed_value;
	} result_t;

	typedef struct packed {
		logic [MAX_ORDER-1:0][4:0] cnt;
		logic [4:0]                free;
		logic [4:0]                val;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_WALK    = 4'b0010,
		S_CELL_RD = 4'b0100,
		S_CELL_WB = 4'b1000
	} state_t;

endpackage

@@ hw/rtl/latin_square_forward_check_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latin_square_forward_check_core
// domain store of a latin square solver: per cell value conflict counts,
// free counts and placed values, updated over the row and column peers
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// command   in         start, busy               item (item_t)
// result    out        result_valid (strobe)     result (result_t)
// config    in         apb psel/penable/pwrite   pwdata, paddr
//
// place and remove walk the 2N row and column slots, skipping the cell
// itself, one per cycle through the single ram port pair, then read and
// write back the cell; query and clear only read it; an out-of-square cell
// is answered from idle; clear drops all per cell valid bits at once, so no
// clearing pass; the result strobe lasts one cycle; the receiver cannot stall it
// ----------------------------------------------------------------------------
module latin_square_forward_check_core
	import lsfc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  item_t       item,
	output logic        result_valid,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t              state_q;
	logic [4:0]          size_q;
	logic [4:0]          nclr_q;
	logic [CELLS-1:0]    valid_q;
	logic [4:0]          n_q;
	logic [3:0]          row_q, col_q, v_q;
	logic                up_q, op_q;
	logic [5:0]          j_q;
	logic [1:0]          st_q;
	logic                pv_s1;
	logic [CELL_W-1:0]   paddr_s1;
	logic                vld_s1;
	logic                result_valid_q;
	result_t             result_q;

	logic [4:0]          n_now;
	logic                accept;
	logic                re, we;
	logic [CELL_W-1:0]   raddr, waddr;
	entry_t              wdata, rdata, ent, upd;
	logic [CELL_W-1:0]   cell_addr;
	logic [5:0]          ji;
	logic                self_peer;
	logic [4:0]          c, nc, nf;
	logic [1:0]          st_add;
	logic [15:0]         mask;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SIZE) ? {27'd0, size_q} : 32'd0;
	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign result_valid = result_valid_q;
	assign result = result_q;
	assign n_now = (size_q < 5'd2) ? 5'd2 : ((size_q > 5'd16) ? 5'd16 : size_q);
	assign cell_addr = {row_q, col_q};

	lsfc_ram #(.WIDTH(ENTRY_W), .DEPTH(CELLS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		ent = rdata;
		if (!vld_s1) begin
			ent.cnt  = '0;
			ent.free = nclr_q;
			ent.val  = 5'd0;
		end
		ji = j_q - {1'b0, n_q};
		self_peer = (j_q < {1'b0, n_q}) ? (j_q[3:0] == col_q) : (ji[3:0] == row_q);
		re = 1'b0;
		raddr = cell_addr;
		if (state_q == S_WALK && j_q < {n_q, 1'b0}) begin
			re = 1'b1;
			raddr = (j_q < {1'b0, n_q}) ? {row_q, j_q[3:0]} : {ji[3:0], col_q};
		end else if (state_q == S_CELL_RD) begin
			re = 1'b1;
		end
		c = ent.cnt[v_q];
		nc = c;
		nf = ent.free;
		st_add = ST_OK;
		if (up_q) begin
			if (c != CNT_MAX) begin
				nc = c + 5'd1;
				if (c == 5'd0 && ent.free != 5'd0) begin
					nf = ent.free - 5'd1;
				end
			end
			if (nf == 5'd0 && ent.val == 5'd0) begin
				st_add = ST_WIPEOUT;
			end
		end else begin
			if (c == 5'd0) begin
				st_add = ST_UNDERFLW;
			end else begin
				nc = c - 5'd1;
				if (c == 5'd1 && ent.free != CNT_MAX) begin
					nf = ent.free + 5'd1;
				end
			end
		end
		upd = ent;
		upd.cnt[v_q] = nc;
		upd.free = nf;
		we = 1'b0;
		waddr = paddr_s1;
		wdata = upd;
		if (state_q == S_WALK && pv_s1) begin
			we = 1'b1;
		end else if (state_q == S_CELL_WB && op_q) begin
			we = 1'b1;
			waddr = cell_addr;
			wdata = ent;
			wdata.val = up_q ? {1'b0, v_q} + 5'd1 : 5'd0;
		end
		for (int k = 0; k < MAX_ORDER; k++) begin
			mask[k] = (k < int'(n_q)) && (ent.cnt[k] == 5'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_q <= RESET_ORDER;
			nclr_q <= RESET_ORDER;
			valid_q <= '0;
			pv_s1 <= 1'b0;
			vld_s1 <= 1'b0;
			result_valid_q <= 1'b0;
			j_q <= '0;
			st_q <= ST_OK;
		end else begin
			result_valid_q <= 1'b0;
			if (psel && penable && pwrite && paddr[2] == REG_SIZE) begin
				size_q <= pwdata[4:0];
			end
			if (re) begin
				vld_s1 <= valid_q[raddr];
			end
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			pv_s1 <= re && (state_q == S_WALK) && !self_peer;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_CLEAR) begin
							valid_q <= '0;
							nclr_q <= n_now;
						end
						j_q <= '0;
						st_q <= ST_OK;
						if ({1'b0, item.cell_row} >= n_now
							|| {1'b0, item.cell_col} >= n_now) begin
							result_valid_q <= 1'b1;
						end else if ((item.cmd == CMD_PLACE || item.cmd == CMD_REMOVE)
							&& item.cell_value >= 5'd1 && item.cell_value <= n_now) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_CELL_RD;
						end
					end
				end
				S_WALK: begin
					if (pv_s1) begin
						st_q <= st_q | st_add;
					end
					if (j_q == {n_q, 1'b0}) begin
						state_q <= S_CELL_RD;
					end else begin
						j_q <= j_q + 6'd1;
					end
				end
				S_CELL_RD: begin
					state_q <= S_CELL_WB;
				end
				S_CELL_WB: begin
					result_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			paddr_s1 <= raddr;
		end
		if (accept) begin
			n_q <= n_now;
			row_q <= item.cell_row;
			col_q <= item.cell_col;
			v_q <= 4'(item.cell_value - 5'd1);
			up_q <= (item.cmd == CMD_PLACE);
			op_q <= (item.cmd == CMD_PLACE || item.cmd == CMD_REMOVE)
				&& item.cell_value >= 5'd1 && item.cell_value <= n_now;
			result_q <= '0;
		end
		if (state_q == S_CELL_WB) begin
			result_q.status <= st_q;
			result_q.free_count <= ent.free;
			result_q.allowed_mask <= mask;
			result_q.placed_value <= op_q ? (up_q ? {1'b0, v_q} + 5'd1 : 5'd0) : ent.val;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy || result_valid)
		else $error("accepted word neither busy nor answered");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status != 2'd3)
		else $error("both status flags set");

	assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> waddr != raddr)
		else $error("ram read and write collide");

endmodule

@@ hw/rtl/lsfc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsfc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lsfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ dv/latin_square_forward_check_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latin_square_forward_check_core_tb
// checks the domain store against a local model: directed words for the
// special cases, then random place/remove/query/clear words over several
// square orders, with random gaps on the command side
// ----------------------------------------------------------------------------
module latin_square_forward_check_core_tb;
	import lsfc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	item_t       item = '0;
	logic        result_valid;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	latin_square_forward_check_core dut (.*);

	always #5 clk = ~clk;

	// model state
	logic [4:0] m_cnt [CELLS][MAX_ORDER];
	logic [4:0] m_free [CELLS];
	logic [4:0] m_val [CELLS];
	logic [4:0] m_size;

	item_t   cmd_queue [$];
	result_t expected_results [$];
	int      errors = 0;
	int      gap_pct = 16;
	int      cycles = 0;

	function automatic int order_now();
		if (m_size < 2) return 2;
		if (m_size > MAX_ORDER) return MAX_ORDER;
		return m_size;
	endfunction

	function automatic void clear_model();
		for (int c = 0; c < CELLS; c++) begin
			for (int k = 0; k < MAX_ORDER; k++) m_cnt[c][k] = '0;
			m_free[c] = 5'(order_now());
			m_val[c] = '0;
		end
	endfunction

	function automatic logic [1:0] touch_peer(int p, int v, bit up);
		logic [1:0] st;
		st = ST_OK;
		if (up) begin
			if (m_cnt[p][v] < CNT_MAX) begin
				m_cnt[p][v]++;
				if (m_cnt[p][v] == 1 && m_free[p] > 0) m_free[p]--;
			end
			if (m_free[p] == 0 && m_val[p] == 0) st = ST_WIPEOUT;
		end else begin
			if (m_cnt[p][v] == 0) st = ST_UNDERFLW;
			else begin
				m_cnt[p][v]--;
				if (m_cnt[p][v] == 0 && m_free[p] < CNT_MAX) m_free[p]++;
			end
		end
		return st;
	endfunction

	function automatic result_t apply_command(item_t it);
		result_t r;
		int n, cell_idx;
		bit up;
		r = '0;
		n = order_now();
		if (it.cmd == CMD_CLEAR) clear_model();
		if (it.cell_row >= n || it.cell_col >= n) return r;
		cell_idx = it.cell_row * MAX_ORDER + it.cell_col;
		if ((it.cmd == CMD_PLACE || it.cmd == CMD_REMOVE) && it.cell_value >= 1 &&
				it.cell_value <= n) begin
			up = (it.cmd == CMD_PLACE);
			for (int i = 0; i < n; i++)
				if (i != it.cell_col)
					r.status |= touch_peer(it.cell_row * MAX_ORDER + i, it.cell_value - 1, up);
			for (int i = 0; i < n; i++)
				if (i != it.cell_row)
					r.status |= touch_peer(i * MAX_ORDER + it.cell_col, it.cell_value - 1, up);
			m_val[cell_idx] = up ? it.cell_value : 5'd0;
			r.status &= up ? ST_WIPEOUT : ST_UNDERFLW;
		end
		for (int k = 0; k < n; k++)
			if (m_cnt[cell_idx][k] == 0) r.allowed_mask[k] = 1'b1;
		r.free_count = m_free[cell_idx];
		r.placed_value = m_val[cell_idx];
		return r;
	endfunction

	function automatic void enqueue_cmd(item_t it);
		cmd_queue.insert(cmd_queue.size(), it);
	endfunction

	// driver
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (start && !busy) begin
			if (cmd_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
				item <= cmd_queue.pop_front();
				start <= 1'b1;
			end else
				start <= 1'b0;
		end else if (!start && cmd_queue.size() > 0 && $urandom_range(99) >= gap_pct) begin
			item <= cmd_queue.pop_front();
			start <= 1'b1;
		end
	end

	// predict on acceptance
	always @(posedge clk) begin
		if (arst_n && start && !busy)
			expected_results.insert(expected_results.size(), apply_command(item));
	end

	// monitor
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && result_valid) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected word %h", $time, result);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result !== exp_r) begin
					$display("%0t: mismatch expected %h actual %h", $time, exp_r, result);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > 400000) begin
			$display("latin_square_forward_check_core_tb: errors");
			$finish;
		end
	end

	task automatic write_size(logic [4:0] n);
		@(posedge clk);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= {REG_SIZE, 2'b00}; pwdata <= 32'(n);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		m_size = n;
	endtask

	task automatic drain();
		while (cmd_queue.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic item_t mk(logic [1:0] c, int r, int co, int v);
		item_t it;
		it.cmd = c; it.cell_row = 4'(r); it.cell_col = 4'(co); it.cell_value = 5'(v);
		return it;
	endfunction

	task automatic random_phase(int count, int n);
		item_t it;
		int roll;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			it = item_t'(15'($urandom));
			if (roll < 94) begin
				it.cell_row = 4'($urandom_range(n - 1));
				it.cell_col = 4'($urandom_range(n - 1));
				it.cell_value = 5'($urandom_range(n, 1));
				it.cmd = (roll < 45) ? CMD_PLACE : (roll < 75) ? CMD_REMOVE :
					(roll < 93) ? CMD_QUERY : CMD_CLEAR;
			end
			enqueue_cmd(it);
		end
	endtask

	initial begin
		m_size = RESET_ORDER;
		clear_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// directed, order 10 from reset
		enqueue_cmd(mk(CMD_PLACE, 0, 0, 1));
		enqueue_cmd(mk(CMD_PLACE, 0, 0, 2));
		enqueue_cmd(mk(CMD_PLACE, 0, 1, 1));
		enqueue_cmd(mk(CMD_QUERY, 9, 9, 0));
		enqueue_cmd(mk(CMD_REMOVE, 5, 5, 3));
		enqueue_cmd(mk(CMD_REMOVE, 0, 1, 1));
		enqueue_cmd(mk(CMD_PLACE, 15, 15, 31));
		enqueue_cmd(mk(CMD_PLACE, 2, 3, 0));
		enqueue_cmd(mk(CMD_REMOVE, 2, 3, 11));
		enqueue_cmd(mk(CMD_QUERY, 10, 0, 1));
		enqueue_cmd(mk(CMD_CLEAR, 12, 3, 0));
		enqueue_cmd(mk(CMD_PLACE, 9, 9, 10));
		drain();
		// order 2: wipeout and saturation
		write_size(5'd2);
		enqueue_cmd(mk(CMD_CLEAR, 0, 0, 0));
		enqueue_cmd(mk(CMD_PLACE, 0, 1, 1));
		enqueue_cmd(mk(CMD_PLACE, 1, 0, 2));
		for (int i = 0; i < 33; i++) enqueue_cmd(mk(CMD_PLACE, 0, 0, 2));
		enqueue_cmd(mk(CMD_QUERY, 0, 1, 0));
		drain();
		// random phases over several orders
		write_size(5'd0);
		enqueue_cmd(mk(CMD_CLEAR, 0, 0, 0));
		random_phase(150, 2);
		drain();
		write_size(5'd31);
		enqueue_cmd(mk(CMD_CLEAR, 0, 0, 0));
		random_phase(300, 16);
		drain();
		gap_pct = 68;
		write_size(5'd4);
		enqueue_cmd(mk(CMD_CLEAR, 0, 0, 0));
		random_phase(350, 4);
		drain();
		gap_pct = 0;
		write_size(5'd16);
		enqueue_cmd(mk(CMD_CLEAR, 0, 0, 0));
		random_phase(250, 16);
		drain();
		write_size(5'd7);
		enqueue_cmd(mk(CMD_CLEAR, 0, 0, 0));
		random_phase(250, 7);
		drain();
		if (errors == 0)
			$display("latin_square_forward_check_core_tb: clean");
		else
			$display("latin_square_forward_check_core_tb: errors");
		$finish;
	end

endmodule
